[design/spu_pkg.sv]
// Shared types and constants for the stack push/pop unit.
`default_nettype none

package spu_pkg;

    // Instruction codes carried in the command field
    typedef enum logic [2:0] {
        CMD_PUSH_PAIR = 3'd0,
        CMD_POP_PAIR  = 3'd1,
        CMD_PUSH_PSW  = 3'd2,
        CMD_POP_PSW   = 3'd3,
        CMD_SPHL      = 3'd4
    } spu_cmd_code_t;

    // Bit positions of the flags inside the pushed status byte
    localparam int unsigned STAT_ZERO   = 0;
    localparam int unsigned STAT_SIGN   = 1;
    localparam int unsigned STAT_PARITY = 2;
    localparam int unsigned STAT_CARRY  = 3;
    localparam int unsigned STAT_AUX    = 4;

    // Input transaction
    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  pair_index;
        logic [15:0] value;
        logic [7:0]  acc_in;
        logic        zero_in;
        logic        sign_in;
        logic        parity_in;
        logic        carry_in;
        logic        aux_carry_in;
    } spu_in_t;

    // Result transaction
    typedef struct packed {
        logic [15:0] value_out;
        logic [1:0]  pair_out;
        logic [7:0]  acc_out;
        logic        zero_out;
        logic        sign_out;
        logic        parity_out;
        logic        carry_out;
        logic        aux_carry_out;
        logic [15:0] sp_out;
    } spu_out_t;

    // Stack memory access issued by the controller
    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_WR_HI,
        MEM_WR_LO,
        MEM_RD_LO,
        MEM_RD_HI
    } spu_mem_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic        load_in;
        spu_mem_op_t mem_op;
        logic        grab_lo;
        logic        finish;
    } spu_ctl_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_LO,
        ST_POP_HI,
        ST_POP_END,
        ST_FINISH
    } spu_state_t;

endpackage

`default_nettype wire

[design/spu_ctrl.sv]
// Controller state machine of the stack push/pop unit.
`default_nettype none

module spu_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire logic [2:0]       command,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output spu_pkg::spu_ctl_t     ctl
);
    import spu_pkg::*;

    spu_state_t state_reg;
    spu_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Output register can take a new result this cycle
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctl.load_in = 1'b0;
        ctl.mem_op  = MEM_IDLE;
        ctl.grab_lo = 1'b0;
        ctl.finish  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_in = 1'b1;
                    case (command)
                        CMD_PUSH_PAIR, CMD_PUSH_PSW:
                        begin
                            ctl.mem_op = MEM_WR_HI;
                            state_next = ST_PUSH_LO;
                        end
                        CMD_POP_PAIR, CMD_POP_PSW:
                        begin
                            ctl.mem_op = MEM_RD_LO;
                            state_next = ST_POP_HI;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_PUSH_LO:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    ctl.mem_op = MEM_WR_LO;
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_POP_HI:
            begin
                ctl.mem_op  = MEM_RD_HI;
                ctl.grab_lo = 1'b1;
                state_next  = ST_POP_END;
            end
            ST_POP_END, ST_FINISH:
            begin
                if (out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.finish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
    end

endmodule

`default_nettype wire

[design/spu_dp.sv]
// Datapath of the stack push/pop unit: stack pointer, stack memory, result register.
`default_nettype none

module spu_dp #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spu_pkg::spu_ctl_t ctl,
    input  wire spu_pkg::spu_in_t  cmd,
    output spu_pkg::spu_out_t      rsp
);
    import spu_pkg::*;

    localparam int unsigned DEPTH = 2 ** ADDR_BITS;

    logic [7:0]           mem [DEPTH];
    logic [7:0]           rdata_reg;
    logic [15:0]          sp_reg;
    logic [15:0]          sp_next;
    logic [2:0]           cmd_reg;
    logic [1:0]           pair_reg;
    logic [15:0]          value_reg;
    logic [7:0]           lo_reg;
    logic [7:0]           lo_next;
    logic [7:0]           status_byte;
    logic [15:0]          offset;
    logic [15:0]          addr_sum;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           wdata;
    logic                 mem_we;
    logic                 mem_re;
    spu_out_t             rsp_reg;
    spu_out_t             rsp_next;

    assign status_byte = {3'b000, cmd.aux_carry_in, cmd.carry_in, cmd.parity_in,
                          cmd.sign_in, cmd.zero_in};

    // Address offset per access; wraps modulo the 16-bit pointer space
    always_comb
    begin
        offset = 16'h0000;
        wdata  = 8'h00;
        mem_we = 1'b0;
        mem_re = 1'b0;
        case (ctl.mem_op)
            MEM_WR_HI:
            begin
                offset = 16'hFFFF;
                wdata  = (cmd.command == CMD_PUSH_PSW) ? cmd.acc_in : cmd.value[15:8];
                mem_we = 1'b1;
            end
            MEM_WR_LO:
            begin
                offset = 16'hFFFE;
                wdata  = lo_reg;
                mem_we = 1'b1;
            end
            MEM_RD_LO:
            begin
                mem_re = 1'b1;
            end
            MEM_RD_HI:
            begin
                offset = 16'h0001;
                mem_re = 1'b1;
            end
            default:
            begin
                offset = 16'h0000;
            end
        endcase
    end

    assign addr_sum = sp_reg + offset;
    assign addr     = addr_sum[ADDR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[addr];
    end

    // Low byte: pushed byte on a push, popped low byte on a pop
    always_comb
    begin
        lo_next = lo_reg;
        if (ctl.load_in)
            lo_next = (cmd.command == CMD_PUSH_PSW) ? status_byte : cmd.value[7:0];
        else if (ctl.grab_lo)
            lo_next = rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        if (ctl.load_in)
        begin
            cmd_reg   <= cmd.command;
            pair_reg  <= cmd.pair_index;
            value_reg <= cmd.value;
        end
        if (ctl.finish)
            rsp_reg <= rsp_next;
    end

    always_comb
    begin
        case (cmd_reg) inside
            CMD_PUSH_PAIR, CMD_PUSH_PSW: sp_next = sp_reg - 16'd2;
            CMD_POP_PAIR, CMD_POP_PSW:   sp_next = sp_reg + 16'd2;
            CMD_SPHL:                    sp_next = value_reg;
            default:                     sp_next = sp_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= 16'h0000;
        else if (ctl.finish)
            sp_reg <= sp_next;
    end

    // Result fields are zero unless the instruction produces them
    always_comb
    begin
        rsp_next        = '0;
        rsp_next.sp_out = sp_next;
        if (cmd_reg == CMD_POP_PAIR)
        begin
            rsp_next.value_out = {rdata_reg, lo_reg};
            rsp_next.pair_out  = pair_reg;
        end
        if (cmd_reg == CMD_POP_PSW)
        begin
            rsp_next.acc_out       = rdata_reg;
            rsp_next.zero_out      = lo_reg[STAT_ZERO];
            rsp_next.sign_out      = lo_reg[STAT_SIGN];
            rsp_next.parity_out    = lo_reg[STAT_PARITY];
            rsp_next.carry_out     = lo_reg[STAT_CARRY];
            rsp_next.aux_carry_out = lo_reg[STAT_AUX];
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

[design/stack_push_pop_unit.sv]
// Top level of the stack push/pop unit: controller, datapath and checks.
`default_nettype none

// Channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// cmd      | cmd_valid/cmd_stall  | spu_in_t: command, pair, value, acc, flags
// rsp      | rsp_valid/rsp_stall  | spu_out_t: popped word/psw, pair, new sp
//
// Pops pass ST_POP_HI and ST_POP_END: the byte-wide stack memory has one port
// with a registered read, so a pop reads the low byte, then the high byte.
// Reset clears the stack pointer and the output valid; the stack memory is
// not cleared. A result waits in the output register while rsp_stall is
// high, and the next transaction is accepted meanwhile; that one holds in
// its last step until the output register frees up.

module stack_push_pop_unit #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire spu_pkg::spu_in_t cmd,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output spu_pkg::spu_out_t     rsp
);
    import spu_pkg::*;

    spu_ctl_t ctl;

    // Sequence the memory accesses and own the handshakes
    spu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (cmd.command),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    // Stack pointer, stack memory and the result register
    spu_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // An accepted transaction always leaves the controller busy, so it cannot take another back to back
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall
    ) else $error("command accepted back to back");

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.finish |-> !(rsp_valid && rsp_stall)
    ) else $error("result register overwritten while stalled");

    // A popped pair word and a popped psw never appear together
    a_pop_kinds_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.value_out != 16'h0000) |->
            (rsp.acc_out == 8'h00 && !rsp.zero_out && !rsp.sign_out &&
             !rsp.parity_out && !rsp.carry_out && !rsp.aux_carry_out)
    ) else $error("pair and psw results mixed");

endmodule

`default_nettype wire

[tb/spu_stack_checker.sv]
// Checker for the stack push/pop unit: predicts every result and compares the response channel.
module spu_stack_checker #(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  spu_pkg::spu_in_t  cmd,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  spu_pkg::spu_out_t rsp,
    output int                fail_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import spu_pkg::*;

    localparam logic [31:0] ADDR_MASK = (32'd1 << ADDR_BITS) - 32'd1;
    localparam int          REPORT_MAX = 10;

    logic [15:0] stack_ptr;
    logic [7:0]  stack_bytes [0:65535];
    spu_out_t    pending_results [$];
    spu_out_t    predicted;
    int          mismatches;

    function automatic logic [15:0] byte_addr(input logic [15:0] base, input logic [15:0] offset);
        logic [15:0] sum;
        sum = base + offset;
        return sum & ADDR_MASK[15:0];
    endfunction

    // Apply one stack instruction to the mirrored state and form its result.
    task automatic execute_stack_op(input spu_in_t op, output spu_out_t res);
        logic [7:0] hi_byte;
        logic [7:0] lo_byte;
        res     = '0;
        hi_byte = 8'h00;
        lo_byte = 8'h00;
        case (op.command)
            CMD_PUSH_PAIR, CMD_PUSH_PSW:
            begin
                if (op.command == CMD_PUSH_PAIR)
                begin
                    hi_byte = op.value[15:8];
                    lo_byte = op.value[7:0];
                end
                else
                begin
                    hi_byte              = op.acc_in;
                    lo_byte[STAT_ZERO]   = op.zero_in;
                    lo_byte[STAT_SIGN]   = op.sign_in;
                    lo_byte[STAT_PARITY] = op.parity_in;
                    lo_byte[STAT_CARRY]  = op.carry_in;
                    lo_byte[STAT_AUX]    = op.aux_carry_in;
                end
                // offsets of all ones and all ones minus one stand for sp-1 and sp-2
                stack_bytes[byte_addr(stack_ptr, 16'hFFFF)] = hi_byte;
                stack_bytes[byte_addr(stack_ptr, 16'hFFFE)] = lo_byte;
                stack_ptr = stack_ptr - 16'd2;
            end
            CMD_POP_PAIR, CMD_POP_PSW:
            begin
                lo_byte   = stack_bytes[byte_addr(stack_ptr, 16'h0000)];
                hi_byte   = stack_bytes[byte_addr(stack_ptr, 16'h0001)];
                stack_ptr = stack_ptr + 16'd2;
                if (op.command == CMD_POP_PAIR)
                begin
                    res.value_out = {hi_byte, lo_byte};
                    res.pair_out  = op.pair_index;
                end
                else
                begin
                    res.acc_out       = hi_byte;
                    res.zero_out      = lo_byte[STAT_ZERO];
                    res.sign_out      = lo_byte[STAT_SIGN];
                    res.parity_out    = lo_byte[STAT_PARITY];
                    res.carry_out     = lo_byte[STAT_CARRY];
                    res.aux_carry_out = lo_byte[STAT_AUX];
                end
            end
            CMD_SPHL:
                stack_ptr = op.value;
            default:
                ;
        endcase
        res.sp_out = stack_ptr;
    endtask

    task automatic compare_result(input spu_out_t want, input spu_out_t got);
        int bad_fields;
        bad_fields = 0;
        if (got.value_out !== want.value_out)         bad_fields++;
        if (got.pair_out !== want.pair_out)           bad_fields++;
        if (got.acc_out !== want.acc_out)             bad_fields++;
        if (got.zero_out !== want.zero_out)           bad_fields++;
        if (got.sign_out !== want.sign_out)           bad_fields++;
        if (got.parity_out !== want.parity_out)       bad_fields++;
        if (got.carry_out !== want.carry_out)         bad_fields++;
        if (got.aux_carry_out !== want.aux_carry_out) bad_fields++;
        if (got.sp_out !== want.sp_out)               bad_fields++;
        if (bad_fields != 0)
        begin
            fail_count++;
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %0d field(s) wrong; expected value %h pair %0d acc %h zspca %b%b%b%b%b sp %h, got value %h pair %0d acc %h zspca %b%b%b%b%b sp %h",
                         $realtime, bad_fields,
                         want.value_out, want.pair_out, want.acc_out, want.zero_out,
                         want.sign_out, want.parity_out, want.carry_out, want.aux_carry_out,
                         want.sp_out,
                         got.value_out, got.pair_out, got.acc_out, got.zero_out,
                         got.sign_out, got.parity_out, got.carry_out, got.aux_carry_out,
                         got.sp_out);
        end
    endtask

    // Check the response first: a command taken at this edge cannot answer at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_ptr = '0;
            pending_results.delete();
            pending_count = 0;
            fail_count    = 0;
            mismatches    = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: response transaction with none outstanding, sp %h",
                                 $realtime, rsp.sp_out);
                end
                else
                    compare_result(pending_results.pop_front(), rsp);
            end
            if (cmd_valid && !cmd_stall)
            begin
                execute_stack_op(cmd, predicted);
                pending_results.push_back(predicted);
            end
            pending_count = pending_results.size();
        end
    end

endmodule

[tb/tb_stack_push_pop_unit.sv]
// Testbench top for the stack push/pop unit: clock, reset, stimulus and verdict.
module tb_stack_push_pop_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spu_pkg::*;

    localparam real        CLK_HALF     = 5.0;
    localparam int         ITEM_TARGET  = 1800;
    localparam int         PHASE_LEN    = 150;
    localparam int         MAX_WAIT     = 13;
    // Longest legal quiet stretch is a full sender gap plus a full stall plus
    // a pop's passage through the controller; allow many times that.
    localparam int         IDLE_LIMIT   = 500;
    localparam int         DRAIN_CYCLES = 20;

    // Codes above SPHL are not instructions; the block must leave its state alone.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // Flag sets in status byte order (zero in bit 0 up to aux carry in bit 4)
    localparam logic [4:0] FLAGS_NONE       = 5'h00;
    localparam logic [4:0] FLAGS_ALL        = 5'h1F;
    localparam logic [4:0] FLAGS_CARRY_ONLY = 5'b00001 << STAT_CARRY;
    localparam logic [4:0] FLAGS_Z_P_AC     = (5'b00001 << STAT_ZERO)
                                            | (5'b00001 << STAT_PARITY)
                                            | (5'b00001 << STAT_AUX);

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    spu_in_t  cmd       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    spu_out_t rsp;

    int fail_count;
    int pending_count;

    // Calm phases run both channels with no idle cycles at all.
    bit calm = 1'b0;

    // Stimulus-side mirror of the stack pointer and of which bytes hold data,
    // so that a pop is only issued where both bytes were pushed before.
    logic [15:0] sp_track = 16'h0000;
    bit          byte_written [0:65535];
    int          sent_by_code [0:7] = '{default: 0};
    int          results_taken = 0;

    always #(CLK_HALF) clk = ~clk;

    stack_push_pop_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    spu_stack_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic spu_in_t make_item(input logic [2:0] code, input logic [1:0] pair,
                                          input logic [15:0] word, input logic [7:0] acc,
                                          input logic [4:0] flags);
        spu_in_t it;
        it.command      = code;
        it.pair_index   = pair;
        it.value        = word;
        it.acc_in       = acc;
        it.zero_in      = flags[STAT_ZERO];
        it.sign_in      = flags[STAT_SIGN];
        it.parity_in    = flags[STAT_PARITY];
        it.carry_in     = flags[STAT_CARRY];
        it.aux_carry_in = flags[STAT_AUX];
        return it;
    endfunction

    function automatic bit pop_legal();
        logic [15:0] upper;
        upper = sp_track + 16'd1;
        return byte_written[sp_track] && byte_written[upper];
    endfunction

    // Draw one instruction. Pops fall back to pushes where the stack holds
    // nothing readable, so most traffic is push/pop pairs with random content;
    // SPHL jumps back into filled stack, onto the wrap points, or anywhere.
    function automatic spu_in_t random_item();
        int          pick;
        logic [2:0]  code;
        logic [15:0] hop;
        spu_in_t     it;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            code = CMD_PUSH_PAIR;
        else if (pick < 45)
            code = CMD_PUSH_PSW;
        else if (pick < 70)
            code = pop_legal() ? CMD_POP_PAIR : CMD_PUSH_PAIR;
        else if (pick < 88)
            code = pop_legal() ? CMD_POP_PSW : CMD_PUSH_PSW;
        else if (pick < 95)
            code = CMD_SPHL;
        else
            code = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        it = make_item(code, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        if (code == CMD_SPHL)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    hop      = 16'(2 * $urandom_range(1, 8));
                    it.value = sp_track + hop;
                end
                1:
                begin
                    case ($urandom_range(0, 3))
                        0:       it.value = 16'h0000;
                        1:       it.value = 16'h0001;
                        2:       it.value = 16'hFFFE;
                        default: it.value = 16'hFFFF;
                    endcase
                end
                default:
                    ;
            endcase
        end
        return it;
    endfunction

    // Present one transaction after a random gap and hold it until taken.
    // Valid drops only when a gap follows, so back-to-back transactions keep
    // it high without a second assignment in the same step.
    task automatic send_cmd(input spu_in_t item);
        int          gap;
        logic [15:0] addr_hi;
        logic [15:0] addr_lo;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // Advance the mirror only once the block has taken the transaction.
        addr_hi = sp_track - 16'd1;
        addr_lo = sp_track - 16'd2;
        case (item.command)
            CMD_PUSH_PAIR, CMD_PUSH_PSW:
            begin
                byte_written[addr_hi] = 1'b1;
                byte_written[addr_lo] = 1'b1;
                sp_track              = addr_lo;
            end
            CMD_POP_PAIR, CMD_POP_PSW:
                sp_track = sp_track + 16'd2;
            CMD_SPHL:
                sp_track = item.value;
            default:
                ;
        endcase
        sent_by_code[item.command]++;
    endtask

    // Drop valid, then hold off until every predicted result has come back.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
    endtask

    initial
    begin : stimulus
        spu_in_t item;
        int      counted;
        int      phase_left;
        int      spare_total;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the stack downward from zero, so the first push wraps to the
        // top of memory, with extreme words and flag sets including a lone carry.
        send_cmd(make_item(CMD_PUSH_PAIR, 2'd3, 16'hFFFF, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_PUSH_PSW,  2'd0, 16'h0000, 8'hFF, FLAGS_ALL));
        send_cmd(make_item(CMD_PUSH_PSW,  2'd1, 16'hFFFF, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_PUSH_PAIR, 2'd0, 16'h0000, 8'hFF, FLAGS_ALL));
        send_cmd(make_item(CMD_PUSH_PSW,  2'd2, 16'h0000, 8'h5A, FLAGS_CARRY_ONLY));
        // Pair words read back as status: upper status bits set, then all flags set.
        send_cmd(make_item(CMD_PUSH_PAIR, 2'd1, 16'h12E0, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_PUSH_PAIR, 2'd2, 16'h341F, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_POP_PSW,   2'd0, 16'h0000, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_POP_PSW,   2'd3, 16'hFFFF, 8'hFF, FLAGS_ALL));
        send_cmd(make_item(CMD_POP_PSW,   2'd0, 16'h0000, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_POP_PAIR,  2'd2, 16'h0000, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_POP_PSW,   2'd1, 16'h0000, 8'h00, FLAGS_NONE));
        // A push psw read back as a pair, then the last pop wraps sp to zero.
        send_cmd(make_item(CMD_POP_PAIR,  2'd1, 16'h0000, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_POP_PAIR,  2'd3, 16'h0000, 8'h00, FLAGS_NONE));
        // A word that straddles the wrap point in both directions.
        send_cmd(make_item(CMD_SPHL,      2'd0, 16'h0001, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_PUSH_PAIR, 2'd0, 16'hA55A, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_POP_PAIR,  2'd3, 16'h0000, 8'h00, FLAGS_NONE));
        // Spare codes with junk fields must leave sp alone.
        send_cmd(make_item(CMD_SPARE_FIRST, 2'd3, 16'hFFFF, 8'hFF, FLAGS_ALL));
        send_cmd(make_item(CMD_SPHL,      2'd0, 16'hFFFF, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_SPARE_LAST, 2'd2, 16'h8001, 8'h7E, FLAGS_Z_P_AC));
        send_cmd(make_item(CMD_PUSH_PSW,  2'd0, 16'h0000, 8'h81, FLAGS_Z_P_AC));
        send_cmd(make_item(CMD_POP_PSW,   2'd0, 16'h0000, 8'h00, FLAGS_NONE));
        send_cmd(make_item(CMD_SPHL,      2'd0, 16'h0000, 8'h00, FLAGS_NONE));

        // Hold off once for sure, so a transaction arrives at a fully idle block.
        wait_drained();

        counted    = 0;
        phase_left = 0;
        while (counted < ITEM_TARGET)
        begin
            if (phase_left == 0)
            begin
                calm       = ($urandom_range(0, 3) == 0);
                phase_left = PHASE_LEN;
                if ($urandom_range(0, 2) == 0)
                    wait_drained();
            end
            item = random_item();
            send_cmd(item);
            // Spare codes do nothing, so they do not count toward the total.
            if (item.command <= CMD_SPHL)
            begin
                counted++;
                phase_left--;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        spare_total = 0;
        for (int code = CMD_SPARE_FIRST; code <= CMD_SPARE_LAST; code++)
            spare_total += sent_by_code[code];
        $display("covered %0d push pair, %0d push psw, %0d pop pair, %0d pop psw,",
                 sent_by_code[CMD_PUSH_PAIR], sent_by_code[CMD_PUSH_PSW],
                 sent_by_code[CMD_POP_PAIR], sent_by_code[CMD_POP_PSW]);
        $display("%0d sphl, %0d spare; %0d results checked, wrap at both ends, gaps 0 to %0d",
                 sent_by_code[CMD_SPHL], spare_total, results_taken, MAX_WAIT);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver: stall for a random count before each result, then take it.
    initial
    begin : response_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            results_taken++;
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
